>>> rtl/dis_pkg.sv
// shared widths and record types for the descending insertion sorter
package dis_pkg;

  localparam int KEY_W       = 16;
  localparam int TAG_W       = 8;
  localparam int DEPTH_DFLT  = 32;

  // contents of one cell of the chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } dis_rec_t;

  // control broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } dis_ctl_t;

endpackage

>>> rtl/dis_cell.sv
// one compare-and-shift cell of the sorting chain
module dis_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dis_pkg::dis_ctl_t ctl,
  input  logic              prev_keep,
  input  dis_pkg::dis_rec_t prev_rec,
  input  dis_pkg::dis_rec_t next_rec,
  output logic              keep,
  output dis_pkg::dis_rec_t rec
);
  import dis_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [TAG_W-1:0] tag_r;
  dis_rec_t         rec_nxt;

  assign rec  = '{valid: valid_r, key: key_r, tag: tag_r};
  // stored records with key >= new key stay put, keeping arrival order on ties
  assign keep = valid_r && (key_r >= ctl.key);

  always_comb begin
    rec_nxt = rec;
    if (ctl.ins) begin
      if (!keep) begin
        if (prev_keep) begin
          rec_nxt = '{valid: 1'b1, key: ctl.key, tag: ctl.tag};
        end else begin
          rec_nxt = prev_rec;
        end
      end
    end else if (ctl.shift) begin
      rec_nxt = next_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rec_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= rec_nxt.key;
    tag_r <= rec_nxt.tag;
  end

endmodule

>>> rtl/descending_insertion_sorter.sv
// stable descending insertion sorter built from a chain of compare-and-shift cells
//
//  channel  ports                                        direction
//  in       in_valid in_stall in_key in_tag in_last_in   word in
//  out      out_valid out_stall out_sorted_key           word out
//           out_sorted_tag out_overflow out_last_out
//
// one word is accepted per cycle while in_stall is low; all cells compare against the new key in parallel
// a word with last_in starts a drain of one word per cycle while out_stall is low
// in_stall is high during the drain; the chain shifts toward cell 0 on each output taken
// reset empties the chain and clears the overflow flag; no clearing pass is needed
// a word arriving with the chain full is dropped and flags overflow on the words of its set
module descending_insertion_sorter #(
  parameter int DEPTH = dis_pkg::DEPTH_DFLT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [dis_pkg::KEY_W-1:0] in_key,
  input  logic [dis_pkg::TAG_W-1:0] in_tag,
  input  logic                      in_last_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [dis_pkg::KEY_W-1:0] out_sorted_key,
  output logic [dis_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                      out_overflow,
  output logic                      out_last_out
);
  import dis_pkg::*;

  logic       drain_r, drain_nxt;
  logic       ovf_r, ovf_nxt;
  logic       in_acc, out_acc, full;
  dis_ctl_t   ctl;
  dis_rec_t   recs [DEPTH];
  logic       keeps [DEPTH];
  logic [DEPTH-1:0] vld_vec;
  logic [DEPTH:0]   vld_inc;

  assign full     = recs[DEPTH-1].valid;
  assign in_stall = drain_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign ctl = '{ins: in_acc && !full, shift: out_acc, key: in_key, tag: in_tag};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      dis_rec_t pr, nr;
      logic     pk;
      if (gi == 0) begin : g_head
        assign pk = 1'b1;
        assign pr = '{valid: 1'b1, key: in_key, tag: in_tag};
      end else begin : g_body
        assign pk = keeps[gi-1];
        assign pr = recs[gi-1];
      end
      if (gi == DEPTH-1) begin : g_tail
        assign nr = '{valid: 1'b0, key: recs[gi].key, tag: recs[gi].tag};
      end else begin : g_mid
        assign nr = recs[gi+1];
      end
      dis_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .prev_keep (pk),
        .prev_rec  (pr),
        .next_rec  (nr),
        .keep      (keeps[gi]),
        .rec       (recs[gi])
      );
      assign vld_vec[gi] = recs[gi].valid;
    end
  endgenerate

  assign out_valid      = drain_r && recs[0].valid;
  assign out_sorted_key = recs[0].key;
  assign out_sorted_tag = recs[0].tag;
  assign out_overflow   = ovf_r;
  assign out_last_out   = !recs[1].valid;

  always_comb begin
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    if (in_acc) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end
      if (in_last_in) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_acc && out_last_out) begin
      drain_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // valid cells always form a prefix of the chain
  assign vld_inc = {1'b0, vld_vec} + {{DEPTH{1'b0}}, 1'b1};

  a_prefix : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(vld_inc))
    else $error("cell valid bits are not a prefix");

  a_start : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_in |=> out_valid)
    else $error("last word did not start output");

  a_cont : assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_last_out |=> out_valid)
    else $error("output run ended early");

  a_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last_out |=> !out_valid && !out_overflow && !in_stall)
    else $error("block not cleared after final output");

endmodule

>>> tb/sort_board_pkg.sv
`timescale 1ns / 100ps
// scoreboard class that predicts each sorted run and checks the output words
package sort_board_pkg;
  import dis_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DFLT;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             overflow;
    logic             last;
  } ranked_word_t;

  class sorted_run_board;
    logic [KEY_W-1:0] keys [STORE_DEPTH];
    logic [TAG_W-1:0] tags [STORE_DEPTH];
    int unsigned      fill;
    bit               dropped;
    ranked_word_t     ranked_due [$];
    int unsigned      faults;

    function new();
      fill    = 0;
      dropped = 0;
      faults  = 0;
    endfunction

    // insert one accepted record; a last record releases the whole run
    function void note_record(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic l);
      int unsigned  pos;
      ranked_word_t w;
      if (fill < STORE_DEPTH) begin
        pos = fill;
        // equal keys stay ahead of the new record
        while (pos > 0 && keys[pos-1] < k) begin
          keys[pos] = keys[pos-1];
          tags[pos] = tags[pos-1];
          pos--;
        end
        keys[pos] = k;
        tags[pos] = t;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (l) begin
        for (int unsigned i = 0; i < fill; i++) begin
          w.key      = keys[i];
          w.tag      = tags[i];
          w.overflow = dropped;
          w.last     = (i + 1 == fill);
          ranked_due.push_back(w);
        end
        fill    = 0;
        dropped = 1'b0;
      end
    endfunction

    function void report_fault(string msg);
      if (faults < 10) $display("%s", msg);
      faults++;
    endfunction

    function void check_word(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic ovf, logic l);
      ranked_word_t w;
      if (ranked_due.size() == 0) begin
        report_fault($sformatf("unexpected word: key %h tag %h ovf %b last %b",
                               k, t, ovf, l));
      end else begin
        w = ranked_due.pop_front();
        if (k !== w.key || t !== w.tag || ovf !== w.overflow || l !== w.last) begin
          report_fault($sformatf(
            "mismatch: expected key %h tag %h ovf %b last %b, got key %h tag %h ovf %b last %b",
            w.key, w.tag, w.overflow, w.last, k, t, ovf, l));
        end
      end
    endfunction

    function int unsigned pending();
      return ranked_due.size();
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// top-level testbench for the descending insertion sorter
module tb_top;
  import dis_pkg::*;
  import sort_board_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 50;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [KEY_W-1:0] in_key;
  logic [TAG_W-1:0] in_tag;
  logic             in_last_in;
  logic             out_valid;
  logic             out_stall;
  logic [KEY_W-1:0] out_sorted_key;
  logic [TAG_W-1:0] out_sorted_tag;
  logic             out_overflow;
  logic             out_last_out;

  int unsigned      sender_idle_pct;
  int unsigned      recv_stall_pct;
  bit               hold_request;
  int unsigned      quiet_cycles;
  sorted_run_board  board;

  descending_insertion_sorter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key         (in_key),
    .in_tag         (in_tag),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_key (out_sorted_key),
    .out_sorted_tag (out_sorted_tag),
    .out_overflow   (out_overflow),
    .out_last_out   (out_last_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // keys lean toward duplicates and extremes so ties and full shifts happen often
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_W'($urandom_range(3, 0));
      4:       return KEY_W'($urandom_range(65535, 65532));
      default: return KEY_W'($urandom_range(65535, 0));
    endcase
  endfunction

  function automatic int unsigned pick_set_size();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 65) return $urandom_range(6, 1);
    if (r < 85) return $urandom_range(32, 7);
    return $urandom_range(40, 32);
  endfunction

  task automatic send_record(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                             input logic l);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid   <= 1'b0;
      in_key     <= KEY_W'($urandom);
      in_tag     <= TAG_W'($urandom);
      in_last_in <= 1'($urandom);
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_key     <= k;
    in_tag     <= t;
    in_last_in <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_record(k, t, l);
    @(negedge clk);
  endtask

  task automatic send_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_record(pick_key(), TAG_W'($urandom_range(255, 0)), i == n - 1);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_sorted_key, out_sorted_tag, out_overflow, out_last_out);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase_count;
    int unsigned idle_table [4];
    int unsigned stall_table [4];
    int unsigned n;

    idle_table  = '{0, 77, 0, 15};
    stall_table = '{0, 0, 77, 15};
    board           = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_key          = '0;
    in_tag          = '0;
    in_last_in      = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-word runs at the key and tag extremes
    send_record('1, '1, 1'b1);
    send_record('0, '0, 1'b1);
    // ties keep arrival order
    send_record(16'd5, 8'd1, 1'b0);
    send_record(16'd9, 8'd2, 1'b0);
    send_record(16'd5, 8'd3, 1'b0);
    send_record(16'd0, 8'd4, 1'b0);
    send_record(16'd5, 8'd5, 1'b0);
    send_record(16'd9, 8'd6, 1'b1);
    // ascending input moves every stored word, then descending keys in the same run land beside their equals
    for (int i = 1; i <= 4; i++) send_record(KEY_W'(i), TAG_W'(8'h10 + i), 1'b0);
    for (int i = 4; i >= 1; i--) send_record(KEY_W'(i), TAG_W'(8'h20 + i), i == 1);

    // exactly full, last word dropped, and a run held back while input keeps coming
    send_set(STORE_DEPTH);
    send_set(STORE_DEPTH + 1);
    hold_request = 1'b1;
    send_set(STORE_DEPTH + 8);

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_table[p];
      recv_stall_pct  = stall_table[p];
      phase_count     = 0;
      while (phase_count < PHASE_ITEMS) begin
        n = pick_set_size();
        send_set(n);
        phase_count += n;
      end
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (board.faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
